[hw/rtl/mngw_pkg.sv]
// Shared types and constants for the Markov n-gram word generator.
package mngw_pkg;

    localparam logic [2:0] ACT_ALPHA = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_TRANS = 3'd2;
    localparam logic [2:0] ACT_SEED  = 3'd3;
    localparam logic [2:0] ACT_GEN   = 3'd4;

    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_ORDER = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;
    localparam logic [3:0]  CLEAR_LEVEL = 4'd10;

    localparam int START_AW = 15;
    localparam int TRANS_AW = 20;

    typedef struct packed {
        logic [2:0]  action;
        logic [19:0] table_index;
        logic [7:0]  char_code;
        logic [3:0]  level_value;
        logic [31:0] seed_value;
        logic [4:0]  word_length;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_last;
        logic       success;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_word_t;

endpackage

[hw/rtl/mngw_if.sv]
// Valid/ready channel interfaces for input, output and configuration words.
interface mngw_in_if;
    logic                valid;
    logic                ready;
    mngw_pkg::in_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mngw_out_if;
    logic                valid;
    logic                ready;
    mngw_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mngw_cfg_if;
    logic                valid;
    logic                ready;
    mngw_pkg::cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mngw_level_ram.sv]
// Level table memory with a registered read port.
module mngw_level_ram #(
    parameter int AW = 15
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [3:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [3:0]    rdata
);
    logic [3:0] mem [2**AW];
    logic [3:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;
endmodule

[hw/rtl/markov_ngram_word_generator_core.sv]
// Top level: Markov n-gram word generator with a shared LCG multiplier and a step sequencer.
// Sequence: a generate word runs tries; each try draws the prefix symbols, each reduced modulo n
// by compare-subtract, then scans the alphabet at each position and draws among the best symbols;
// the result then leaves one character per cycle while the receiver is ready.
// Throughput: one word at a time; the next word is taken once the last result has left.
// Reset: registers clear at once; a clearing pass then writes level 10 to every table entry.
module markov_ngram_word_generator_core #(
    parameter int MAX_SYMBOLS = 32,
    parameter int MAX_ORDER   = 4,
    parameter int MAX_WORD    = 30,
    parameter int MAX_TRIES   = 100
) (
    input logic clk,
    input logic rst_n,
    mngw_in_if.sink    in_ch,
    mngw_out_if.source out_ch,
    mngw_cfg_if.sink   cfg
);
    localparam int CAP = (MAX_SYMBOLS < 32) ? MAX_SYMBOLS : 32;
    localparam int TW  = $clog2(MAX_TRIES + 1);
    localparam int PW  = $clog2(MAX_WORD + 1);

    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_TRY   = 13'b0000000000100,
        S_PDRAW = 13'b0000000001000,
        S_PMOD  = 13'b0000000010000,
        S_SREAD = 13'b0000000100000,
        S_SCHK  = 13'b0000001000000,
        S_SCAN  = 13'b0000010000000,
        S_SCHK2 = 13'b0000100000000,
        S_PICK  = 13'b0001000000000,
        S_PMOD2 = 13'b0010000000000,
        S_EMIT  = 13'b0100000000000,
        S_FAIL  = 13'b1000000000000
    } state_t;

    state_t state_reg;

    logic [5:0]  size_reg;
    logic [2:0]  order_reg;
    logic [3:0]  limit_reg;
    logic [31:0] rng_reg;
    logic [7:0]  alpha_mem [32];
    logic [4:0]  word_mem [MAX_WORD];
    logic [4:0]  best_mem [32];
    logic [19:0] clr_reg;
    logic [4:0]  len_reg;
    logic [PW-1:0] pos_reg;
    logic [TW-1:0] try_reg;
    logic [5:0]  cnt_reg;
    logic [4:0]  sym_reg;
    logic [4:0]  best_reg;
    logic [5:0]  n_reg;
    logic [15:0] mod_reg;
    logic [4:0]  k_reg;
    logic        ovalid_reg;
    mngw_pkg::out_word_t odata_reg;

    // Effective size and order.
    logic [5:0] n_eff;
    logic [2:0] g_eff;
    always_comb
    begin
        n_eff = (size_reg == 6'd0) ? 6'd1 : size_reg;
        if (n_eff > 6'(CAP))
            n_eff = 6'(CAP);
        g_eff = (order_reg < 3'd2) ? 3'd2 : order_reg;
        if (g_eff > 3'(MAX_ORDER))
            g_eff = 3'(MAX_ORDER);
    end
    logic [2:0] plen;
    assign plen = g_eff - 3'd1;

    logic [31:0] rng_step;
    assign rng_step = rng_reg * mngw_pkg::LCG_MUL + mngw_pkg::LCG_ADD;

    // Level tables; the clearing pass writes level 10.
    logic        st_we, tr_we;
    logic [mngw_pkg::START_AW-1:0] st_wa, st_ra;
    logic [mngw_pkg::TRANS_AW-1:0] tr_wa, tr_ra;
    logic [3:0]  st_wd, tr_wd, st_rd, tr_rd;
    logic        clearing;
    assign clearing = (state_reg == S_CLR);

    mngw_level_ram #(
        .AW (mngw_pkg::START_AW)
    ) i_start_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_wa),
        .wdata (st_wd),
        .raddr (st_ra),
        .rdata (st_rd)
    );

    mngw_level_ram #(
        .AW (mngw_pkg::TRANS_AW)
    ) i_trans_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_wa),
        .wdata (tr_wd),
        .raddr (tr_ra),
        .rdata (tr_rd)
    );

    logic in_fire;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        st_we = clearing || (in_fire && in_ch.data.action == mngw_pkg::ACT_START);
        st_wa = clearing ? clr_reg[14:0] : in_ch.data.table_index[14:0];
        st_wd = clearing ? mngw_pkg::CLEAR_LEVEL : in_ch.data.level_value;
        tr_we = clearing || (in_fire && in_ch.data.action == mngw_pkg::ACT_TRANS);
        tr_wa = clearing ? clr_reg : in_ch.data.table_index;
        tr_wd = clearing ? mngw_pkg::CLEAR_LEVEL : in_ch.data.level_value;
    end

    // Prefix key from word buffer at pos-plen..pos-1.
    logic [19:0] pkey;
    always_comb
    begin
        pkey = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (3'(i) < plen)
                pkey = {pkey[14:0], word_mem[PW'(pos_reg - PW'(plen) + PW'(i))]};
        end
    end
    assign st_ra = pkey[14:0];
    assign tr_ra = {pkey[14:0], sym_reg};

    // Shared reduce: (rng >> 16) mod n by compare-subtract of 64 * n, then of n.
    logic [15:0] n64;
    logic [15:0] n16;
    logic        mod_done;
    assign n64 = {4'd0, n_reg, 6'd0};
    assign n16 = {10'd0, n_reg};
    assign mod_done = (mod_reg < n16);

    // Scan compare of one transition level against the best so far.
    logic lv_ok, lv_lt, lv_eq;
    assign lv_ok = (tr_rd <= limit_reg);
    assign lv_lt = ({1'b0, tr_rd} < best_reg);
    assign lv_eq = ({1'b0, tr_rd} == best_reg);

    logic          wm_we;
    logic [PW-1:0] wm_wa;
    logic [4:0]    wm_wd;
    logic          bm_we;
    logic [4:0]    bm_wa;
    logic [4:0]    bm_wd;
    always_comb
    begin
        wm_we = mod_done && (state_reg == S_PMOD || state_reg == S_PMOD2);
        wm_wa = pos_reg;
        wm_wd = (state_reg == S_PMOD) ? mod_reg[4:0] : best_mem[mod_reg[4:0]];
        bm_we = (state_reg == S_SCHK2) && lv_ok && (lv_lt || lv_eq);
        bm_wa = lv_lt ? 5'd0 : cnt_reg[4:0];
        bm_wd = sym_reg;
    end

    logic out_fire;
    logic out_load;
    assign out_fire = ovalid_reg && out_ch.ready;
    assign out_load = (state_reg == S_EMIT || state_reg == S_FAIL)
                      && (!ovalid_reg || out_ch.ready);

    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.data.action == mngw_pkg::ACT_ALPHA
            && in_ch.data.table_index < 20'(CAP))
            alpha_mem[in_ch.data.table_index[4:0]] <= in_ch.data.char_code;
    end

    always_ff @(posedge clk)
    begin
        if (wm_we)
            word_mem[wm_wa] <= wm_wd;
        if (bm_we)
            best_mem[bm_wa] <= bm_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            size_reg   <= 6'd32;
            order_reg  <= 3'd4;
            limit_reg  <= 4'd5;
            rng_reg    <= '0;
            ovalid_reg <= 1'b0;
            len_reg    <= '0;
            pos_reg    <= '0;
            try_reg    <= '0;
            cnt_reg    <= '0;
            sym_reg    <= '0;
            best_reg   <= '0;
            n_reg      <= '0;
            mod_reg    <= '0;
            k_reg      <= '0;
            odata_reg  <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.data.index)
                    mngw_pkg::REG_SIZE:  size_reg  <= cfg.data.data[5:0];
                    mngw_pkg::REG_ORDER: order_reg <= cfg.data.data[2:0];
                    mngw_pkg::REG_LIMIT: limit_reg <= cfg.data.data[3:0];
                    default: ;
                endcase
            end
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (out_fire)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 20'd1;
                    if (clr_reg == 20'hFFFFF)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (in_ch.data.action)
                            mngw_pkg::ACT_SEED: rng_reg <= in_ch.data.seed_value;
                            mngw_pkg::ACT_GEN:
                            begin
                                len_reg <= in_ch.data.word_length;
                                try_reg <= '0;
                                if (in_ch.data.word_length < {2'b0, g_eff}
                                    || 32'(in_ch.data.word_length) > 32'(MAX_WORD))
                                    state_reg <= S_FAIL;
                                else
                                    state_reg <= S_TRY;
                            end
                            default: ;
                        endcase
                    end
                end
                S_TRY:
                begin
                    if (try_reg == TW'(MAX_TRIES))
                        state_reg <= S_FAIL;
                    else
                    begin
                        pos_reg   <= '0;
                        try_reg   <= try_reg + TW'(1);
                        state_reg <= S_PDRAW;
                    end
                end
                S_PDRAW:
                begin
                    rng_reg   <= rng_step;
                    mod_reg   <= rng_step[31:16];
                    n_reg     <= n_eff;
                    state_reg <= S_PMOD;
                end
                S_PMOD:
                begin
                    if (mod_reg >= n64)
                        mod_reg <= mod_reg - n64;
                    else if (!mod_done)
                        mod_reg <= mod_reg - n16;
                    else
                    begin
                        pos_reg <= pos_reg + PW'(1);
                        state_reg <= (pos_reg + PW'(1) == PW'(plen)) ? S_SREAD : S_PDRAW;
                    end
                end
                S_SREAD: state_reg <= S_SCHK;
                S_SCHK:
                begin
                    sym_reg  <= '0;
                    cnt_reg  <= '0;
                    best_reg <= 5'd16;
                    k_reg    <= '0;
                    state_reg <= (st_rd > limit_reg) ? S_TRY : S_SCAN;
                end
                S_SCAN: state_reg <= S_SCHK2;
                S_SCHK2:
                begin
                    if (lv_ok)
                    begin
                        if (lv_lt)
                        begin
                            best_reg <= {1'b0, tr_rd};
                            cnt_reg  <= 6'd1;
                        end
                        else if (lv_eq)
                            cnt_reg <= cnt_reg + 6'd1;
                    end
                    sym_reg <= sym_reg + 5'd1;
                    if (6'(sym_reg) + 6'd1 == n_eff)
                        state_reg <= S_PICK;
                    else
                        state_reg <= S_SCAN;
                end
                S_PICK:
                begin
                    if (cnt_reg == 6'd0)
                        state_reg <= S_TRY;
                    else
                    begin
                        rng_reg   <= rng_step;
                        mod_reg   <= rng_step[31:16];
                        n_reg     <= cnt_reg;
                        state_reg <= S_PMOD2;
                    end
                end
                S_PMOD2:
                begin
                    if (mod_reg >= n64)
                        mod_reg <= mod_reg - n64;
                    else if (!mod_done)
                        mod_reg <= mod_reg - n16;
                    else
                    begin
                        pos_reg  <= pos_reg + PW'(1);
                        sym_reg  <= '0;
                        cnt_reg  <= '0;
                        best_reg <= 5'd16;
                        state_reg <= (pos_reg + PW'(1) == PW'(len_reg)) ? S_EMIT : S_SCAN;
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        odata_reg.out_char <= alpha_mem[word_mem[PW'(k_reg)]];
                        odata_reg.is_last  <= (k_reg + 5'd1 == len_reg);
                        odata_reg.success  <= 1'b1;
                        k_reg <= k_reg + 5'd1;
                        if (k_reg + 5'd1 == len_reg)
                            state_reg <= S_IDLE;
                    end
                end
                S_FAIL:
                begin
                    if (out_load)
                    begin
                        odata_reg <= '{out_char: 8'd0, is_last: 1'b1, success: 1'b0};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;
endmodule

[dv/mngw_tb_if_note.sv]
// Testbench constants; the channel interfaces come from the RTL.
package mngw_tb_consts;
    localparam int WORD_GAP_MAX = 15;
endpackage

[dv/tb_markov_ngram_word_generator_core.sv]
// Testbench for the Markov n-gram word generator: loads tables, generates words, checks characters.
module tb_markov_ngram_word_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 60_000_000;
    localparam int  SETTLE_CYCLES = 16;
    localparam int  WORD_MAX = 30;
    localparam int  TRIES = 100;
    localparam int  RANDOM_WORDS = 126;

    logic clk;
    logic rst_n;

    mngw_in_if  in_ch ();
    mngw_out_if out_ch ();
    mngw_cfg_if cfg ();

    markov_ngram_word_generator_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    // Shadow of the block state.
    logic [5:0]  size_reg;
    logic [2:0]  order_reg;
    logic [3:0]  limit_reg;
    logic [7:0]  alphabet [0:31];
    logic [3:0]  start_lv [int];
    logic [3:0]  trans_lv [int];
    logic [31:0] lcg_state;
    logic [4:0]  word_syms [0:WORD_MAX-1];
    logic [4:0]  best_syms [0:31];

    mngw_pkg::out_word_t pending_chars [$];
    bit          send_gaps;
    bit          sink_stalls;
    int          errors;
    int          cycles;
    int          words_sent;
    int          gen_words;
    int          chars_seen;
    int          words_made;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [3:0] start_level(int idx);
        return start_lv.exists(idx) ? start_lv[idx] : mngw_pkg::CLEAR_LEVEL;
    endfunction

    function automatic logic [3:0] trans_level(int idx);
        return trans_lv.exists(idx) ? trans_lv[idx] : mngw_pkg::CLEAR_LEVEL;
    endfunction

    function automatic int eff_size();
        if (size_reg == 0)
            return 1;
        return (size_reg > 32) ? 32 : int'(size_reg);
    endfunction

    function automatic int eff_order();
        if (order_reg < 2)
            return 2;
        return (order_reg > 4) ? 4 : int'(order_reg);
    endfunction

    function automatic int lcg_draw(int n);
        lcg_state = lcg_state * mngw_pkg::LCG_MUL + mngw_pkg::LCG_ADD;
        return int'(lcg_state >> 16) % n;
    endfunction

    function automatic int pack_syms(int first, int count);
        int v;
        v = 0;
        for (int i = 0; i < count; i++)
            v = (v << 5) | int'(word_syms[first + i]);
        return v;
    endfunction

    function automatic bit try_word(int n, int plen, int len, int lim);
        int base;
        int best;
        int cnt;
        int lv;
        for (int i = 0; i < plen; i++)
            word_syms[i] = 5'(lcg_draw(n));
        if (start_level(pack_syms(0, plen) & 32'h7fff) > lim)
            return 1'b0;
        for (int pos = plen; pos < len; pos++)
        begin
            base = pack_syms(pos - plen, plen) << 5;
            best = 16;
            cnt = 0;
            for (int c = 0; c < n; c++)
            begin
                lv = trans_level((base | c) & 32'hfffff);
                if (lv > lim)
                    continue;
                if (lv < best)
                begin
                    best = lv;
                    cnt = 0;
                end
                if (lv == best)
                begin
                    best_syms[cnt] = 5'(c);
                    cnt++;
                end
            end
            if (cnt == 0)
                return 1'b0;
            word_syms[pos] = best_syms[lcg_draw(cnt)];
        end
        return 1'b1;
    endfunction

    // Works out the words a generate request produces and updates the shadow on loads.
    function automatic void predict_word(mngw_pkg::in_word_t w);
        int len;
        int g;
        mngw_pkg::out_word_t r;
        case (w.action)
            mngw_pkg::ACT_ALPHA:
                if (w.table_index < 32) alphabet[w.table_index[4:0]] = w.char_code;
            mngw_pkg::ACT_START: start_lv[int'(w.table_index) & 32'h7fff] = w.level_value;
            mngw_pkg::ACT_TRANS: trans_lv[int'(w.table_index)] = w.level_value;
            mngw_pkg::ACT_SEED:  lcg_state = w.seed_value;
            mngw_pkg::ACT_GEN:
            begin
                gen_words++;
                len = w.word_length;
                g = eff_order();
                if (len >= g && len <= WORD_MAX)
                begin
                    for (int t = 0; t < TRIES; t++)
                    begin
                        if (try_word(eff_size(), g - 1, len, limit_reg))
                        begin
                            for (int k = 0; k < len; k++)
                            begin
                                r.out_char = alphabet[word_syms[k]];
                                r.is_last = (k == len - 1);
                                r.success = 1'b1;
                                pending_chars.push_back(r);
                            end
                            words_made++;
                            return;
                        end
                    end
                end
                r.out_char = 8'd0;
                r.is_last = 1'b1;
                r.success = 1'b0;
                pending_chars.push_back(r);
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        mngw_pkg::out_word_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            chars_seen++;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected result char=%h last=%b ok=%b", $time,
                         out_ch.data.out_char, out_ch.data.is_last, out_ch.data.success);
                errors++;
            end
            else
            begin
                e = pending_chars.pop_front();
                if (e.out_char !== out_ch.data.out_char)
                begin
                    $display("%0t: out_char expected %h actual %h", $time, e.out_char,
                             out_ch.data.out_char);
                    errors++;
                end
                if (e.is_last !== out_ch.data.is_last)
                begin
                    $display("%0t: is_last expected %b actual %b", $time, e.is_last,
                             out_ch.data.is_last);
                    errors++;
                end
                if (e.success !== out_ch.data.success)
                begin
                    $display("%0t: success expected %b actual %b", $time, e.success,
                             out_ch.data.success);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls in bursts.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_word(mngw_pkg::in_word_t w);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, mngw_tb_consts::WORD_GAP_MAX)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_word(w);
        words_sent++;
    endtask

    function automatic mngw_pkg::in_word_t make_word(logic [2:0] act, logic [19:0] idx,
                                                     logic [7:0] ch, logic [3:0] lv,
                                                     logic [31:0] seed, logic [4:0] len);
        mngw_pkg::in_word_t w;
        w.action = act;
        w.table_index = idx;
        w.char_code = ch;
        w.level_value = lv;
        w.seed_value = seed;
        w.word_length = len;
        return w;
    endfunction

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.data.index <= idx;
        cfg.data.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            mngw_pkg::REG_SIZE:  size_reg = value[5:0];
            mngw_pkg::REG_ORDER: order_reg = value[2:0];
            mngw_pkg::REG_LIMIT: limit_reg = value[3:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int sz, int ord, int lim);
        wait_idle();
        write_reg(mngw_pkg::REG_SIZE,
                  {$urandom_range(0, 1) ? $urandom() : 32'd0} & ~32'h3f | 32'(sz));
        write_reg(mngw_pkg::REG_ORDER, 32'(ord));
        write_reg(mngw_pkg::REG_LIMIT, 32'(lim));
        cfg.valid <= 1'b0;
    endtask

    task automatic gen(int len);
        send_word(make_word(mngw_pkg::ACT_GEN, 20'($urandom()), 8'($urandom()),
                            4'($urandom()), $urandom(), 5'(len)));
    endtask

    function automatic logic [19:0] rand_key(int syms, int n);
        logic [19:0] k;
        k = '0;
        for (int i = 0; i < syms; i++)
            k = (k << 5) | 20'($urandom_range(0, n - 1));
        return k;
    endfunction

    // Distinct characters: the low five bits carry the slot number.
    task automatic test_alphabet_load();
        for (int i = 0; i < 32; i++)
            send_word(make_word(mngw_pkg::ACT_ALPHA, 20'(i), {3'($urandom()), 5'(i)},
                                '0, '0, '0));
        send_word(make_word(mngw_pkg::ACT_ALPHA, 20'd32, 8'hff, '0, '0, '0));
        send_word(make_word(mngw_pkg::ACT_ALPHA, 20'hfffff, 8'h00, '0, '0, '0));
    endtask

    task automatic test_reset_tables();
        // Every start entry is at the clear level, above the reset limit.
        gen(4);
        gen(30);
    endtask

    task automatic test_bad_lengths();
        gen(0);
        gen(3);
        gen(31);
        send_word(make_word(3'd5, 20'hfffff, 8'hff, 4'hf, 32'hffffffff, 5'h1f));
        send_word(make_word(3'd6, 20'h0, 8'h0, 4'h0, 32'h0, 5'h0));
        send_word(make_word(3'd7, 20'h5a5a5, 8'ha5, 4'h5, 32'h5a5a5a5a, 5'h15));
        gen(4);
    endtask

    task automatic test_register_extremes();
        // Size zero acts as one symbol and order zero as two.
        set_regs(0, 0, 15);
        send_word(make_word(mngw_pkg::ACT_SEED, '0, '0, '0, 32'hffffffff, '0));
        gen(2);
        gen(30);
        gen(1);
        set_regs(63, 7, 10);
        gen(5);
        set_regs(32, 4, 0);
        send_word(make_word(mngw_pkg::ACT_START, 20'hf8021, '0, 4'd0, '0, '0));
        send_word(make_word(mngw_pkg::ACT_TRANS, 20'hfffff, '0, 4'd0, '0, '0));
        send_word(make_word(mngw_pkg::ACT_TRANS, 20'h00421, '0, 4'd0, '0, '0));
        send_word(make_word(mngw_pkg::ACT_START, 20'h7fff, '0, 4'd15, '0, '0));
        gen(4);
        set_regs(2, 1, 15);
        gen(6);
    endtask

    task automatic random_phase(int words, int sz, int ord, int lim, bit pause);
        int g;
        int r;
        set_regs(sz, ord, lim);
        g = eff_order();
        for (int i = 0; i < words; i++)
        begin
            r = $urandom_range(0, 99);
            if (pause && i == words / 2)
                wait_idle();
            if (r < 35)
                send_word(make_word(mngw_pkg::ACT_TRANS,
                                    ($urandom_range(0, 9) == 0) ? 20'($urandom()) :
                                    rand_key(g, eff_size()), 8'($urandom()),
                                    4'($urandom()), $urandom(), 5'($urandom())));
            else if (r < 50)
                send_word(make_word(mngw_pkg::ACT_START,
                                    ($urandom_range(0, 9) == 0) ? 20'($urandom()) :
                                    rand_key(g - 1, eff_size()), 8'($urandom()),
                                    4'($urandom()), $urandom(), 5'($urandom())));
            else if (r < 58)
                send_word(make_word(mngw_pkg::ACT_SEED, 20'($urandom()), 8'($urandom()),
                                    4'($urandom()), $urandom(), 5'($urandom())));
            else if (r < 64)
            begin
                int slot;
                slot = $urandom_range(0, 40);
                send_word(make_word(mngw_pkg::ACT_ALPHA, 20'(slot), {3'($urandom()), 5'(slot)},
                                    4'($urandom()), $urandom(), 5'($urandom())));
            end
            else if (r < 68)
                send_word(make_word(3'($urandom_range(5, 7)), 20'($urandom()), 8'($urandom()),
                                    4'($urandom()), $urandom(), 5'($urandom())));
            else if (r < 94)
                gen($urandom_range(g, (sz > 8) ? 10 : 14));
            else
                gen($urandom_range(0, 31));
        end
    endtask

    task automatic test_random();
        send_gaps = 1'b1;
        sink_stalls = 1'b1;
        random_phase(30, 4, 3, $urandom_range(9, 12), 1'b1);
        random_phase(25, $urandom_range(2, 6), 2, $urandom_range(0, 15), 1'b0);
        random_phase(25, $urandom_range(2, 5), 4, $urandom_range(8, 15), 1'b1);
        random_phase(10, 32, 3, 15, 1'b0);
        send_gaps = 1'b0;
        sink_stalls = 1'b0;
        random_phase(RANDOM_WORDS - 90, 3, 3, 11, 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        errors = 0;
        cycles = 0;
        words_sent = 0;
        gen_words = 0;
        chars_seen = 0;
        words_made = 0;
        send_gaps = 1'b0;
        sink_stalls = 1'b1;
        size_reg = 6'd32;
        order_reg = 3'd4;
        limit_reg = 4'd5;
        lcg_state = '0;
        for (int i = 0; i < 32; i++)
            alphabet[i] = 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_alphabet_load();
        test_reset_tables();
        test_bad_lengths();
        test_register_extremes();
        test_random();

        wait_idle();
        repeat (200) @(posedge clk);
        $display("Sent %0d words, %0d generate requests, %0d built words, %0d results checked",
                 words_sent, gen_words, words_made, chars_seen);
        $display("Register settings covered sizes 0 to 63, orders 0 to 7, limits 0 to 15");
        if (errors == 0 && pending_chars.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/mngw_pkg.sv
hw/rtl/mngw_if.sv
hw/rtl/mngw_level_ram.sv
hw/rtl/markov_ngram_word_generator_core.sv
dv/mngw_tb_if_note.sv
dv/tb_markov_ngram_word_generator_core.sv
